// ----- rtl/lca_pkg.sv -----
// Shared types and constants for the Euler-tour LCA engine.
// No dependencies; every RTL file but lca_ram imports this package.
`default_nettype none

package lca_pkg;

  localparam int DEF_MAX_NODES    = 512;
  localparam int DEF_MAX_TOUR     = 1024;
  localparam int DEF_TABLE_LEVELS = 10;

  localparam int CMD_W = 2;
  localparam int ID_W  = 9;
  localparam int HT_W  = 9;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIPE,
    ST_QA,
    ST_QB,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_LX,
    ST_LY,
    ST_LW,
    ST_SPAN,
    ST_TX,
    ST_TY,
    ST_TC
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/lca_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lca_span.sv -----
// Query span unit: orders two tour positions, picks the table level and the
// start of the second window. Two register stages. Depends on lca_pkg.
`default_nettype none

module lca_span import lca_pkg::*; #(
  parameter int MAX_TOUR     = DEF_MAX_TOUR,
  parameter int TABLE_LEVELS = DEF_TABLE_LEVELS
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic [$clog2(MAX_TOUR)-1:0]     pa,
  input  logic [$clog2(MAX_TOUR)-1:0]     pb,
  output logic [$clog2(MAX_TOUR)-1:0]     lo,
  output logic [$clog2(MAX_TOUR)-1:0]     start2,
  output logic [$clog2(TABLE_LEVELS)-1:0] lvl
);

  localparam int TW  = $clog2(MAX_TOUR);
  localparam int LW  = $clog2(TABLE_LEVELS);
  localparam int MBW = $clog2(TW);

  logic [TW-1:0]  lo1;
  logic [TW-1:0]  hi1;
  logic [TW-1:0]  diff1;
  logic [MBW-1:0] msb;
  logic [LW-1:0]  lvl_c;
  logic [TW:0]    win;

  always_ff @(posedge clk) begin
    if (load) begin
      if (pa > pb) begin
        lo1   <= pb;
        hi1   <= pa;
        diff1 <= pa - pb;
      end else begin
        lo1   <= pa;
        hi1   <= pb;
        diff1 <= pb - pa;
      end
    end
  end

  // Level is the top set bit of the span minus one, clamped to the last level.
  always_comb begin
    msb = '0;
    for (int i = 0; i < TW; i++) begin
      if (diff1[i]) begin
        msb = MBW'(i);
      end
    end
    if (32'(msb) > TABLE_LEVELS - 1) begin
      lvl_c = LW'(TABLE_LEVELS - 1);
    end else begin
      lvl_c = LW'(msb);
    end
    win = (TW+1)'(1) << lvl_c;
  end

  always_ff @(posedge clk) begin
    lo     <= lo1;
    lvl    <= lvl_c;
    start2 <= TW'(({1'b0, hi1} + (TW+1)'(1)) - win);
  end

endmodule

`default_nettype wire

// ----- rtl/lca_ctrl.sv -----
// Sequencer for the LCA engine: append, clear pass, table build and query.
// Drives both RAM ports and the span unit. Depends on lca_pkg.
`default_nettype none

module lca_ctrl import lca_pkg::*; #(
  parameter int MAX_NODES    = DEF_MAX_NODES,
  parameter int MAX_TOUR     = DEF_MAX_TOUR,
  parameter int TABLE_LEVELS = DEF_TABLE_LEVELS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [ID_W-1:0]       node,
  input  logic [HT_W-1:0]       height,
  input  logic [ID_W-1:0]       other_node,
  output logic                  done,
  output logic [ID_W-1:0]       lca_node,
  output logic                  found,
  // node store port
  output logic                  nm_we,
  output logic [$clog2(MAX_NODES)-1:0] nm_waddr,
  output logic [HT_W+$clog2(MAX_TOUR):0] nm_wdata,
  output logic                  nm_re,
  output logic [$clog2(MAX_NODES)-1:0] nm_raddr,
  input  logic [HT_W+$clog2(MAX_TOUR):0] nm_rdata,
  // sparse table port
  output logic                  tb_we,
  output logic [$clog2(TABLE_LEVELS)+$clog2(MAX_TOUR)-1:0] tb_waddr,
  output logic [ID_W+HT_W-1:0]  tb_wdata,
  output logic                  tb_re,
  output logic [$clog2(TABLE_LEVELS)+$clog2(MAX_TOUR)-1:0] tb_raddr,
  input  logic [ID_W+HT_W-1:0]  tb_rdata,
  // span unit
  output logic                  span_load,
  output logic [$clog2(MAX_TOUR)-1:0] span_pa,
  output logic [$clog2(MAX_TOUR)-1:0] span_pb,
  input  logic [$clog2(MAX_TOUR)-1:0] span_lo,
  input  logic [$clog2(MAX_TOUR)-1:0] span_start2,
  input  logic [$clog2(TABLE_LEVELS)-1:0] span_lvl
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int TW   = $clog2(MAX_TOUR);
  localparam int LW   = $clog2(TABLE_LEVELS);
  localparam int NE_W = 1 + HT_W + TW;
  localparam int TE_W = ID_W + HT_W;

  state_t state;
  state_t state_next;

  logic [TW:0]     tour_len;
  logic            ready;
  logic [NW-1:0]   wipe_idx;
  logic [ID_W-1:0] b_id;
  logic            a_in;
  logic            b_in;
  logic            a_ok;
  logic [TW-1:0]   a_pos;
  logic [TW-1:0]   j;
  logic [LW-1:0]   k;
  logic [TE_W-1:0] x_ent;

  logic            res_fire;
  logic            res_found;
  logic [ID_W-1:0] res_node;

  logic            node_in;
  logic            other_in;
  logic            tour_room;
  logic            q_ok;
  logic [31:0]     w32;
  logic [31:0]     half32;
  logic            lvl0_last;
  logic            lvl_last;
  logic            go_lvl1;
  logic            go_next;
  logic [TE_W-1:0] pick;

  assign busy      = (state != ST_IDLE);
  assign node_in   = 32'(node) < MAX_NODES;
  assign other_in  = 32'(other_node) < MAX_NODES;
  assign tour_room = 32'(tour_len) < MAX_TOUR;
  assign q_ok      = a_ok && b_in && nm_rdata[NE_W-1];
  assign w32       = 32'(1) << k;
  assign half32    = w32 >> 1;
  assign lvl0_last = (32'(j) + 32'd1) == 32'(tour_len);
  assign lvl_last  = (32'(j) + w32) == 32'(tour_len);
  assign go_lvl1   = 32'd2 < 32'(tour_len);
  assign go_next   = ((32'(k) + 32'd1) < TABLE_LEVELS) && ((w32 << 1) < 32'(tour_len));
  // on equal depths the later window wins
  assign pick      = (x_ent[HT_W-1:0] < tb_rdata[HT_W-1:0]) ? x_ent : tb_rdata;
  assign span_pa   = a_pos;
  assign span_pb   = nm_rdata[TW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_CLEAR: state_next = ST_WIPE;
            CMD_QUERY: state_next = ST_QA;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_WIPE: begin
        if (wipe_idx == NW'(MAX_NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_QA: state_next = ST_QB;
      ST_QB: begin
        if (!q_ok) begin
          state_next = ST_IDLE;
        end else if (ready) begin
          state_next = ST_SPAN;
        end else begin
          state_next = ST_R0;
        end
      end
      ST_R0: state_next = ST_R1;
      ST_R1: state_next = ST_R2;
      ST_R2: begin
        if (lvl0_last) begin
          state_next = go_lvl1 ? ST_LX : ST_SPAN;
        end else begin
          state_next = ST_R0;
        end
      end
      ST_LX: state_next = ST_LY;
      ST_LY: state_next = ST_LW;
      ST_LW: begin
        if (lvl_last) begin
          state_next = go_next ? ST_LX : ST_SPAN;
        end else begin
          state_next = ST_LX;
        end
      end
      ST_SPAN: state_next = ST_TX;
      ST_TX:   state_next = ST_TY;
      ST_TY:   state_next = ST_TC;
      ST_TC:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory ports and result
  always_comb begin
    nm_we     = 1'b0;
    nm_waddr  = wipe_idx;
    nm_wdata  = '0;
    nm_re     = 1'b0;
    nm_raddr  = '0;
    tb_we     = 1'b0;
    tb_waddr  = {LW'(0), j};
    tb_wdata  = '0;
    tb_re     = 1'b0;
    tb_raddr  = {LW'(0), j};
    span_load = 1'b0;
    res_fire  = 1'b0;
    res_found = 1'b0;
    res_node  = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_APPEND: begin
              if (node_in && tour_room) begin
                nm_we    = 1'b1;
                nm_waddr = NW'(node);
                nm_wdata = {1'b1, height, TW'(tour_len)};
                tb_we    = 1'b1;
                tb_waddr = {LW'(0), TW'(tour_len)};
                tb_wdata = {node, height};
              end
            end
            CMD_QUERY: begin
              nm_re    = 1'b1;
              nm_raddr = node_in ? NW'(node) : '0;
            end
            default: ;
          endcase
        end
      end
      ST_WIPE: begin
        nm_we = 1'b1;
      end
      ST_QA: begin
        nm_re    = 1'b1;
        nm_raddr = b_in ? NW'(b_id) : '0;
      end
      ST_QB: begin
        span_load = q_ok;
        res_fire  = !q_ok;
      end
      ST_R0: begin
        tb_re = 1'b1;
      end
      ST_R1: begin
        nm_re    = 1'b1;
        nm_raddr = NW'(tb_rdata[TE_W-1 -: ID_W]);
      end
      ST_R2: begin
        // refresh level 0 with the node's current depth
        tb_we    = 1'b1;
        tb_wdata = {x_ent[TE_W-1 -: ID_W], nm_rdata[NE_W-2 -: HT_W]};
      end
      ST_LX: begin
        tb_re    = 1'b1;
        tb_raddr = {LW'(k - LW'(1)), j};
      end
      ST_LY: begin
        tb_re    = 1'b1;
        tb_raddr = {LW'(k - LW'(1)), TW'(32'(j) + half32)};
      end
      ST_LW: begin
        tb_we    = 1'b1;
        tb_waddr = {k, j};
        tb_wdata = pick;
      end
      ST_TX: begin
        tb_re    = 1'b1;
        tb_raddr = {span_lvl, span_lo};
      end
      ST_TY: begin
        tb_re    = 1'b1;
        tb_raddr = {span_lvl, span_start2};
      end
      ST_TC: begin
        res_fire  = 1'b1;
        res_found = 1'b1;
        res_node  = pick[TE_W-1 -: ID_W];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_WIPE;
      tour_len <= '0;
      ready    <= 1'b0;
      wipe_idx <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_fire;
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (cmd)
              CMD_CLEAR: begin
                tour_len <= '0;
                ready    <= 1'b0;
                wipe_idx <= '0;
              end
              CMD_APPEND: begin
                if (node_in && tour_room) begin
                  tour_len <= tour_len + (TW+1)'(1);
                  ready    <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WIPE: wipe_idx <= wipe_idx + NW'(1);
        ST_R2: begin
          if (lvl0_last && !go_lvl1) begin
            ready <= 1'b1;
          end
        end
        ST_LW: begin
          if (lvl_last && !go_next) begin
            ready <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (res_fire) begin
      lca_node <= res_node;
      found    <= res_found;
    end
    case (state)
      ST_IDLE: begin
        b_id <= other_node;
        a_in <= node_in;
        b_in <= other_in;
      end
      ST_QA: begin
        a_ok  <= a_in && nm_rdata[NE_W-1];
        a_pos <= nm_rdata[TW-1:0];
      end
      ST_QB: j <= '0;
      ST_R1: x_ent <= tb_rdata;
      ST_R2: begin
        if (lvl0_last) begin
          j <= '0;
          k <= LW'(1);
        end else begin
          j <= j + TW'(1);
        end
      end
      ST_LY: x_ent <= tb_rdata;
      ST_LW: begin
        if (lvl_last) begin
          j <= '0;
          k <= k + LW'(1);
        end else begin
          j <= j + TW'(1);
        end
      end
      ST_TY: x_ent <= tb_rdata;
      default: ;
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_QB || $past(state) == ST_TC))
    else $error("result strobe without a query");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start && cmd == CMD_APPEND && 32'(tour_len) == MAX_TOUR)
    |=> tour_len == $past(tour_len))
    else $error("append accepted into a full tour");

  a_tb_rw: assert property (@(posedge clk) disable iff (rst)
    !(tb_we && tb_re && tb_waddr == tb_raddr))
    else $error("table read and write hit the same entry");

  a_ready_tx: assert property (@(posedge clk) disable iff (rst) (state == ST_TX) |-> ready)
    else $error("table lookup before the build finished");

endmodule

`default_nettype wire

// ----- rtl/euler_tour_lca_sparse_table.sv -----
// Euler-tour LCA engine: node store, sparse table store, span unit, sequencer.
// Depends on lca_pkg, lca_ram, lca_span, lca_ctrl.
// Append is taken while idle, without raising busy. Clear: one pass over the node store.
// Query: ends early when a node is missing, else goes straight to the lookup with a
// built table; the first query with both nodes present after a change first builds the
// table, level 0 per tour element, then each entry of each higher level. The table RAM
// is never read and written in the same cycle. Reset is synchronous; afterwards busy
// stays high while the node store is swept. done pulses one cycle per query; the receiver cannot stall.
`default_nettype none

module euler_tour_lca_sparse_table import lca_pkg::*; #(
  parameter int MAX_NODES    = DEF_MAX_NODES,
  parameter int MAX_TOUR     = DEF_MAX_TOUR,
  parameter int TABLE_LEVELS = DEF_TABLE_LEVELS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] cmd,
  input  logic [ID_W-1:0]  node,
  input  logic [HT_W-1:0]  height,
  input  logic [ID_W-1:0]  other_node,
  output logic             done,
  output logic [ID_W-1:0]  lca_node,
  output logic             found
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int TW   = $clog2(MAX_TOUR);
  localparam int LW   = $clog2(TABLE_LEVELS);
  localparam int NE_W = 1 + HT_W + TW;
  localparam int TE_W = ID_W + HT_W;
  localparam int TAW  = LW + TW;

  logic            nm_we;
  logic [NW-1:0]   nm_waddr;
  logic [NE_W-1:0] nm_wdata;
  logic            nm_re;
  logic [NW-1:0]   nm_raddr;
  logic [NE_W-1:0] nm_rdata;

  logic            tb_we;
  logic [TAW-1:0]  tb_waddr;
  logic [TE_W-1:0] tb_wdata;
  logic            tb_re;
  logic [TAW-1:0]  tb_raddr;
  logic [TE_W-1:0] tb_rdata;

  logic            span_load;
  logic [TW-1:0]   span_pa;
  logic [TW-1:0]   span_pb;
  logic [TW-1:0]   span_lo;
  logic [TW-1:0]   span_start2;
  logic [LW-1:0]   span_lvl;

  lca_ram #(
    .WIDTH (NE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .re    (nm_re),
    .raddr (nm_raddr),
    .rdata (nm_rdata)
  );

  lca_ram #(
    .WIDTH (TE_W),
    .DEPTH (TABLE_LEVELS << TW)
  ) u_table_ram (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .re    (tb_re),
    .raddr (tb_raddr),
    .rdata (tb_rdata)
  );

  lca_span #(
    .MAX_TOUR     (MAX_TOUR),
    .TABLE_LEVELS (TABLE_LEVELS)
  ) u_span (
    .clk    (clk),
    .load   (span_load),
    .pa     (span_pa),
    .pb     (span_pb),
    .lo     (span_lo),
    .start2 (span_start2),
    .lvl    (span_lvl)
  );

  lca_ctrl #(
    .MAX_NODES    (MAX_NODES),
    .MAX_TOUR     (MAX_TOUR),
    .TABLE_LEVELS (TABLE_LEVELS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .node        (node),
    .height      (height),
    .other_node  (other_node),
    .done        (done),
    .lca_node    (lca_node),
    .found       (found),
    .nm_we       (nm_we),
    .nm_waddr    (nm_waddr),
    .nm_wdata    (nm_wdata),
    .nm_re       (nm_re),
    .nm_raddr    (nm_raddr),
    .nm_rdata    (nm_rdata),
    .tb_we       (tb_we),
    .tb_waddr    (tb_waddr),
    .tb_wdata    (tb_wdata),
    .tb_re       (tb_re),
    .tb_raddr    (tb_raddr),
    .tb_rdata    (tb_rdata),
    .span_load   (span_load),
    .span_pa     (span_pa),
    .span_pb     (span_pb),
    .span_lo     (span_lo),
    .span_start2 (span_start2),
    .span_lvl    (span_lvl)
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for euler_tour_lca_sparse_table: loads Euler tours, asks LCA
// queries and compares every answer against an in-bench sparse-table predictor.
// Depends on lca_pkg and the RTL top level only.
module tb;
  import lca_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_ITEMS     = 360;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 600;

  typedef struct packed {
    logic [ID_W-1:0] lca;
    logic            found;
  } lca_result_t;

  typedef struct packed {
    logic [ID_W-1:0] node;
    logic [HT_W-1:0] height;
  } tour_elem_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [CMD_W-1:0] cmd = CMD_CLEAR;
  logic [ID_W-1:0]  node = '0;
  logic [HT_W-1:0]  height = '0;
  logic [ID_W-1:0]  other_node = '0;
  logic             busy;
  logic             done;
  logic [ID_W-1:0]  lca_node;
  logic             found;

  // predictor state
  bit [HT_W-1:0] depth_mem [DEF_MAX_NODES];
  int            lastpos_mem [DEF_MAX_NODES];
  bit            in_tour [DEF_MAX_NODES];
  bit [ID_W-1:0] rmq [DEF_TABLE_LEVELS][DEF_MAX_TOUR];
  int            tour_len = 0;
  bit            rmq_ready = 1'b0;

  lca_result_t   lca_expected [$];
  logic [ID_W-1:0] live_ids [$];
  tour_elem_t    tour_q [$];
  lca_result_t   want;

  int gap_pct = 0;
  int items_sent = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int n_clear = 0, n_append = 0, n_query = 0, n_found = 0, n_unused = 0, longest_tour = 0;

  euler_tour_lca_sparse_table DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .node       (node),
    .height     (height),
    .other_node (other_node),
    .done       (done),
    .lca_node   (lca_node),
    .found      (found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  function automatic logic [HT_W-1:0] rand_ht();
    return HT_W'($urandom);
  endfunction

  // Equal depths go to the later candidate.
  function automatic logic [ID_W-1:0] shallower(input logic [ID_W-1:0] x,
                                                input logic [ID_W-1:0] y);
    return (depth_mem[x] < depth_mem[y]) ? x : y;
  endfunction

  function automatic void predict_item(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] a,
                                       input logic [HT_W-1:0] h, input logic [ID_W-1:0] b);
    lca_result_t res;
    int p, q, t, len, w, k;
    res = '0;
    case (c)
      CMD_CLEAR: begin
        in_tour = '{default: 1'b0};
        tour_len = 0;
        rmq_ready = 1'b0;
        live_ids.delete();
        n_clear++;
      end
      CMD_APPEND: begin
        n_append++;
        if (tour_len < DEF_MAX_TOUR) begin
          rmq[0][tour_len] = a;
          depth_mem[a] = h;
          lastpos_mem[a] = tour_len;
          in_tour[a] = 1'b1;
          tour_len++;
          rmq_ready = 1'b0;
          live_ids.insert(live_ids.size(), a);
          if (tour_len > longest_tour) longest_tour = tour_len;
        end
      end
      CMD_QUERY: begin
        n_query++;
        if (in_tour[a] && in_tour[b]) begin
          if (!rmq_ready) begin
            for (int lv = 1; lv < DEF_TABLE_LEVELS && (1 << lv) < tour_len; lv++)
              for (int j = 0; j + (1 << lv) <= tour_len; j++)
                rmq[lv][j] = shallower(rmq[lv-1][j], rmq[lv-1][j + (1 << (lv-1))]);
            rmq_ready = 1'b1;
          end
          p = lastpos_mem[a];
          q = lastpos_mem[b];
          if (p > q) begin
            t = p;
            p = q;
            q = t;
          end
          len = q - p + 1;
          w = 1;
          k = 0;
          while (w * 2 < len && k + 1 < DEF_TABLE_LEVELS) begin
            w *= 2;
            k++;
          end
          q = q + 1 - w;
          res.lca = shallower(rmq[k][p], rmq[k][q]);
          res.found = 1'b1;
          n_found++;
        end
        lca_expected.insert(lca_expected.size(), res);
      end
      default: n_unused++;
    endcase
  endfunction

  // Hold start high across back-to-back transfers; drop it only for an idle gap.
  task automatic issue_cmd(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] a,
                           input logic [HT_W-1:0] h, input logic [ID_W-1:0] b);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= c;
    node       <= a;
    height     <= h;
    other_node <= b;
    do @(posedge clk); while (busy !== 1'b0);
    predict_item(c, a, h, b);
    if (c != CMD_UNUSED) items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (lca_expected.size() != 0) @(posedge clk);
  endtask

  task automatic query_pair(input int miss_pct);
    logic [ID_W-1:0] a, b;
    a = (live_ids.size() == 0 || $urandom_range(99) < miss_pct) ? rand_id() :
        live_ids[$urandom_range(live_ids.size() - 1)];
    b = (live_ids.size() == 0 || $urandom_range(99) < miss_pct) ? rand_id() :
        live_ids[$urandom_range(live_ids.size() - 1)];
    if ($urandom_range(99) < 10) b = a;
    issue_cmd(CMD_QUERY, a, rand_ht(), b);
  endtask

  // Random tree walked depth first; heights are tree depth plus a common offset.
  task automatic make_tour(input int n_nodes);
    logic [ID_W-1:0] stack_q [$];
    bit taken [DEF_MAX_NODES];
    tour_elem_t e;
    logic [ID_W-1:0] id;
    int made, base;
    tour_q.delete();
    taken = '{default: 1'b0};
    base = $urandom_range(DEF_MAX_NODES - 1 - n_nodes, 0);
    id = rand_id();
    taken[id] = 1'b1;
    stack_q.insert(stack_q.size(), id);
    made = 1;
    e.node = id;
    e.height = HT_W'(base);
    tour_q.insert(tour_q.size(), e);
    while (made < n_nodes || stack_q.size() > 1) begin
      if (made < n_nodes && (stack_q.size() == 1 || $urandom_range(99) < 55)) begin
        do id = rand_id(); while (taken[id]);
        taken[id] = 1'b1;
        made++;
        stack_q.insert(stack_q.size(), id);
      end else begin
        void'(stack_q.pop_back());
      end
      e.node = stack_q[$];
      e.height = HT_W'(base + stack_q.size() - 1);
      tour_q.insert(tour_q.size(), e);
    end
  endtask

  task automatic test_directed();
    gap_pct = 0;
    issue_cmd(CMD_QUERY, 9'd7, 9'd0, 9'd7);        // empty tour
    issue_cmd(CMD_UNUSED, 9'd511, 9'd511, 9'd511);
    issue_cmd(CMD_APPEND, 9'd511, 9'd0, 9'd0);
    issue_cmd(CMD_APPEND, 9'd0, 9'd511, 9'd511);
    issue_cmd(CMD_APPEND, 9'd511, 9'd0, 9'd0);
    issue_cmd(CMD_QUERY, 9'd0, 9'd511, 9'd511);
    issue_cmd(CMD_QUERY, 9'd511, 9'd0, 9'd0);
    issue_cmd(CMD_QUERY, 9'd0, 9'd0, 9'd0);
    issue_cmd(CMD_QUERY, 9'd511, 9'd511, 9'd511);
    issue_cmd(CMD_QUERY, 9'd0, 9'd0, 9'd300);       // second node unseen
    issue_cmd(CMD_QUERY, 9'd300, 9'd0, 9'd511);     // first node unseen
    // a change after a query forces a rebuild
    issue_cmd(CMD_APPEND, 9'd300, 9'd1, 9'd0);
    issue_cmd(CMD_QUERY, 9'd300, 9'd0, 9'd0);
    // equal heights: the later window has to win
    issue_cmd(CMD_CLEAR, 9'd511, 9'd511, 9'd511);
    for (int i = 1; i <= 5; i++) issue_cmd(CMD_APPEND, ID_W'(i * 10), 9'd5, 9'd0);
    issue_cmd(CMD_QUERY, 9'd10, 9'd0, 9'd50);
    issue_cmd(CMD_QUERY, 9'd40, 9'd0, 9'd20);
    issue_cmd(CMD_QUERY, 9'd10, 9'd0, 9'd20);
    issue_cmd(CMD_CLEAR, 9'd0, 9'd0, 9'd0);
    issue_cmd(CMD_QUERY, 9'd10, 9'd0, 9'd50);
    issue_cmd(CMD_UNUSED, 9'd0, 9'd0, 9'd0);
    drain();
  endtask

  // Fill the tour to capacity, push past it, and query across the whole span.
  task automatic test_full_tour();
    logic [ID_W-1:0] head, ghost, id;
    gap_pct = 30;
    head = rand_id();
    ghost = ~head;
    issue_cmd(CMD_CLEAR, rand_id(), rand_ht(), rand_id());
    issue_cmd(CMD_APPEND, head, rand_ht(), rand_id());
    for (int i = 1; i < DEF_MAX_TOUR + 3; i++) begin
      id = ghost;
      if (i < DEF_MAX_TOUR) begin
        do id = rand_id(); while (id == head || id == ghost);
      end
      issue_cmd(CMD_APPEND, id, rand_ht(), rand_id());
    end
    issue_cmd(CMD_QUERY, head, rand_ht(), live_ids[$]);
    issue_cmd(CMD_QUERY, ghost, rand_ht(), head);
    repeat (10) query_pair(5);
    drain();
  endtask

  task automatic test_random();
    int goal, seq, n;
    logic [CMD_W-1:0] c;
    seq = 0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 45 : (ph == 3) ? 30 : 0;
      goal = items_sent + RAND_ITEMS / 4;
      while (items_sent < goal) begin
        seq++;
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(4, 12)) begin
            c = CMD_W'($urandom_range(3));
            if (c == CMD_CLEAR && $urandom_range(99) < 60) c = CMD_APPEND;
            issue_cmd(c, rand_id(), rand_ht(), rand_id());
          end
        end else begin
          if (live_ids.size() == 0 || live_ids.size() > 150 || $urandom_range(99) < 80)
            issue_cmd(CMD_CLEAR, rand_id(), rand_ht(), rand_id());
          n = ($urandom_range(99) < 10) ? $urandom_range(30, 80) : $urandom_range(1, 12);
          make_tour(n);
          foreach (tour_q[i]) issue_cmd(CMD_APPEND, tour_q[i].node, tour_q[i].height, rand_id());
          repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(99) < 8) issue_cmd(CMD_APPEND, rand_id(), rand_ht(), rand_id());
            query_pair(15);
          end
        end
        if (seq % 6 == 0) drain();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (lca_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual lca_node %0d found %0b",
                 $time, lca_node, found);
        errors++;
      end else begin
        want = lca_expected.pop_front();
        if (lca_node !== want.lca) begin
          $display("%0t: lca_node mismatch, expected %0d, actual %0d", $time, want.lca, lca_node);
          errors++;
        end
        if (found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, found);
          errors++;
        end
      end
    end
  end

  // Count cycles without any transfer in either direction.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0);
    test_directed();
    test_full_tour();
    test_random();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d clears, %0d appends, %0d queries (%0d with both nodes present)",
             n_clear, n_append, n_query, n_found);
    $display("plus %0d unused commands; tours up to %0d elements, appends past capacity",
             n_unused, longest_tour);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
